// File: hdl/pbwd_pkg.sv
// shared types and codes of the protobuf wire field decoder
package pbwd_pkg;

    localparam int unsigned FN_W    = 29;
    localparam int unsigned WT_W    = 3;
    localparam int unsigned VAL_W   = 64;
    localparam int unsigned REM_W   = 31;
    localparam int unsigned BCNT_W  = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FIELD   = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_END     = 2'd3
    } t_kind;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_DATA   = 3'd1,
        ERR_VARINT    = 3'd2,
        ERR_FIELD_NUM = 3'd3,
        ERR_WIRE_TYPE = 3'd4,
        ERR_LENGTH    = 3'd5
    } t_err;

    // wire types
    localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [WT_W-1:0] WT_LENGTH  = 3'd2;
    localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

    // parse phases, one-hot
    typedef enum logic [6:0] {
        PH_TAG     = 7'b0000001,
        PH_VARINT  = 7'b0000010,
        PH_FIX64   = 7'b0000100,
        PH_LEN     = 7'b0001000,
        PH_FIX32   = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_DROP    = 7'b1000000
    } t_phase;

    // byte counts of the fixed wire types
    localparam logic [BCNT_W-1:0] FIX64_BYTES = 4'd8;
    localparam logic [BCNT_W-1:0] FIX32_BYTES = 4'd4;
    // last allowed varint byte index
    localparam logic [BCNT_W-1:0] VARINT_LAST = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        t_kind                    kind;
        logic [FN_W-1:0]          field_id;
        logic [WT_W-1:0]          wtype;
        logic [VAL_W-1:0]         value;
        logic signed [VAL_W-1:0]  value_zigzag;
        logic [7:0]               payload_byte;
        t_err                     error_code;
        logic                     last;
    } t_result;

endpackage

// File: hdl/pbwd_ifs.sv
// channel interfaces of the protobuf wire field decoder
interface pbwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface pbwd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [28:0]        field_id;
    logic [2:0]         wtype;
    logic [63:0]        value;
    logic signed [63:0] value_zigzag;
    logic [7:0]         payload_byte;
    logic [2:0]         error_code;
    logic               last;

    modport source (output valid, output kind, output field_id, output wtype,
                    output value, output value_zigzag, output payload_byte,
                    output error_code, output last, input ready);
    modport sink   (input valid, input kind, input field_id, input wtype,
                    input value, input value_zigzag, input payload_byte,
                    input error_code, input last, output ready);
endinterface

interface pbwd_cfg_if;
    logic valid;
    logic ready;
    logic pass_payload;

    modport source (output valid, output pass_payload, input ready);
    modport sink   (input valid, input pass_payload, output ready);
endinterface

// File: hdl/pbwd_in_stage.sv
// input register stage of the decoder
module pbwd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  pbwd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output pbwd_pkg::t_item o_item
);
    import pbwd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/pbwd_parser.sv
// parse state and per-byte field decode logic
module pbwd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  pbwd_pkg::t_item  i_item,
    input  logic             i_pass_payload,
    output logic             o_res_valid,
    output pbwd_pkg::t_result o_res
);
    import pbwd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [VAL_W-1:0]   r_acc, n_acc;
    logic [BCNT_W-1:0]  r_bcnt, n_bcnt;
    logic [FN_W-1:0]    r_fn, n_fn;
    logic [WT_W-1:0]    r_wt, n_wt;
    logic [REM_W-1:0]   r_rem, n_rem;

    logic [VAL_W+5:0]   acc7;
    logic [VAL_W-1:0]   acc8;
    logic [VAL_W-1:0]   v;
    logic [BCNT_W-1:0]  bcnt_inc;
    logic [BCNT_W-1:0]  need;
    logic [REM_W-1:0]   rem_dec;
    logic [FN_W-1:0]    cur_fn;
    logic [WT_W-1:0]    cur_wt;
    logic               eom;
    logic               fail_en;
    t_err               fail_code;
    logic               done_en;
    logic [VAL_W-1:0]   done_val;
    logic               go_tag;

    assign eom = i_item.end_of_message;

    always_comb begin
        acc7 = {6'd0, r_acc};
        for (int i = 0; i < 10; i++) begin
            if (r_bcnt == BCNT_W'(i)) begin
                acc7[7*i +: 7] = acc7[7*i +: 7] | i_item.data_byte[6:0];
            end
        end
        acc8 = r_acc;
        for (int i = 0; i < 8; i++) begin
            if (r_bcnt[2:0] == 3'(i)) begin
                acc8[8*i +: 8] = acc8[8*i +: 8] | i_item.data_byte;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_bcnt    = r_bcnt;
        n_fn      = r_fn;
        n_wt      = r_wt;
        n_rem     = r_rem;
        cur_fn    = r_fn;
        cur_wt    = r_wt;
        fail_en   = 1'b0;
        fail_code = ERR_NONE;
        done_en   = 1'b0;
        done_val  = '0;
        go_tag    = 1'b0;
        v         = acc7[VAL_W-1:0];
        bcnt_inc  = r_bcnt + 4'd1;
        need      = (r_phase == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
        rem_dec   = (r_rem != '0) ? r_rem - 31'd1 : r_rem;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            PH_TAG, PH_VARINT, PH_LEN: begin
                if (i_item.data_byte[7]) begin
                    if (r_bcnt >= VARINT_LAST) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_VARINT;
                    end else begin
                        n_acc  = v;
                        n_bcnt = bcnt_inc;
                        if (eom) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_NO_DATA;
                        end
                    end
                end else begin
                    n_acc  = '0;
                    n_bcnt = '0;
                    if (r_phase == PH_TAG) begin
                        // tag is cut to 32 bits before splitting
                        cur_fn = v[31:3];
                        cur_wt = v[2:0];
                        n_fn   = cur_fn;
                        n_wt   = cur_wt;
                        if (cur_fn == '0) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_FIELD_NUM;
                        end else begin
                            unique case (cur_wt)
                                WT_VARINT:  n_phase = PH_VARINT;
                                WT_FIXED64: n_phase = PH_FIX64;
                                WT_LENGTH:  n_phase = PH_LEN;
                                WT_FIXED32: n_phase = PH_FIX32;
                                default: begin
                                    fail_en   = 1'b1;
                                    fail_code = ERR_WIRE_TYPE;
                                end
                            endcase
                            if (!fail_en && eom) begin
                                fail_en   = 1'b1;
                                fail_code = ERR_NO_DATA;
                            end
                        end
                    end else if (r_phase == PH_VARINT) begin
                        done_en  = 1'b1;
                        done_val = v;
                        go_tag   = 1'b1;
                    end else begin
                        if (v[VAL_W-1:REM_W] != '0) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_LENGTH;
                        end else if (v == '0) begin
                            done_en = 1'b1;
                            go_tag  = 1'b1;
                        end else if (eom) begin
                            fail_en   = 1'b1;
                            fail_code = ERR_NO_DATA;
                        end else begin
                            n_rem    = v[REM_W-1:0];
                            n_phase  = PH_PAYLOAD;
                            done_en  = 1'b1;
                            done_val = v;
                        end
                    end
                end
            end
            PH_FIX64, PH_FIX32: begin
                if (bcnt_inc >= need) begin
                    done_en  = 1'b1;
                    done_val = acc8;
                    go_tag   = 1'b1;
                end else begin
                    n_acc  = acc8;
                    n_bcnt = bcnt_inc;
                    if (eom) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_NO_DATA;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (rem_dec == '0) begin
                    go_tag = 1'b1;
                    if (i_pass_payload) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_PAYLOAD;
                        o_res.field_id      = r_fn;
                        o_res.wtype         = r_wt;
                        o_res.payload_byte  = i_item.data_byte;
                        o_res.last          = eom;
                    end else if (eom) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_END;
                        o_res.last  = 1'b1;
                    end
                end else begin
                    n_rem = rem_dec;
                    if (eom) begin
                        fail_en   = 1'b1;
                        fail_code = ERR_NO_DATA;
                    end else if (i_pass_payload) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_PAYLOAD;
                        o_res.field_id      = r_fn;
                        o_res.wtype         = r_wt;
                        o_res.payload_byte  = i_item.data_byte;
                    end
                end
            end
            PH_DROP: begin
                if (eom) begin
                    go_tag      = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_END;
                    o_res.last  = 1'b1;
                end
            end
            default: begin
                go_tag = 1'b1;
            end
        endcase

        if (done_en) begin
            o_res_valid        = 1'b1;
            o_res.kind         = KIND_FIELD;
            o_res.field_id     = cur_fn;
            o_res.wtype        = cur_wt;
            o_res.value        = done_val;
            o_res.value_zigzag = {1'b0, done_val[VAL_W-1:1]} ^ {VAL_W{done_val[0]}};
            o_res.last         = eom;
        end

        if (fail_en) begin
            o_res_valid        = 1'b1;
            o_res              = '0;
            o_res.kind         = KIND_ERROR;
            o_res.field_id     = cur_fn;
            o_res.wtype        = cur_wt;
            o_res.error_code   = fail_code;
            o_res.last         = eom;
            go_tag             = 1'b1;
        end

        if (go_tag) begin
            n_phase = (fail_en && !eom) ? PH_DROP : PH_TAG;
            n_acc   = '0;
            n_bcnt  = '0;
            n_fn    = '0;
            n_wt    = '0;
            n_rem   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_acc   <= '0;
            r_bcnt  <= '0;
            r_fn    <= '0;
            r_wt    <= '0;
            r_rem   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_bcnt  <= n_bcnt;
            r_fn    <= n_fn;
            r_wt    <= n_wt;
            r_rem   <= n_rem;
        end
    end

endmodule

// File: hdl/pbwd_out_stage.sv
// result register stage of the decoder
module pbwd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pbwd_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output pbwd_pkg::t_result o_res
);
    import pbwd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_space) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_space) begin
            r_res <= i_res;
        end
    end

endmodule

// File: hdl/protobuf_wire_field_decoder_core.sv
// top level of the protobuf wire field decoder
//
// usage
// - i_byte carries one byte of an encoded message per transaction, with
//   end_of_message set on the final byte of each message
// - o_field carries at most one result per input byte: a completed field
//   (raw value and zigzag value), a payload byte, an error, or a bare
//   message end marker
// - i_cfg writes pass_payload; ready is always high, write only while idle
// - each accepted byte is loaded into the input register, and its result
//   into the result register once that register has space
// - throughput: one byte per cycle unless o_field stalls; the parse state
//   update is one pass of shift/or logic between input and result registers
// - a stalled o_field holds its result; the input register still takes
//   one more byte, after which i_byte.ready drops until o_field drains
// - reset (synchronous, active low) empties both registers, sets the parser
//   to expect a tag and sets pass_payload to 1
module protobuf_wire_field_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbwd_in_if.sink     i_byte,
    pbwd_out_if.source  o_field,
    pbwd_cfg_if.sink    i_cfg
);
    import pbwd_pkg::*;

    logic    r_pass_payload;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    out_space;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_payload <= 1'b1;
        end else if (i_cfg.valid) begin
            r_pass_payload <= i_cfg.pass_payload;
        end
    end

    assign in_item.data_byte      = i_byte.data_byte;
    assign in_item.end_of_message = i_byte.end_of_message;

    // a byte is decoded whenever the result register can take its result
    assign step = stage_valid && out_space;

    pbwd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .o_ready (i_byte.ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (step),
        .o_item  (stage_item)
    );

    pbwd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (stage_item),
        .i_pass_payload (r_pass_payload),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    pbwd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .o_space (out_space),
        .o_valid (o_field.valid),
        .i_ready (o_field.ready),
        .o_res   (out_res)
    );

    // result transaction fields
    assign o_field.kind         = out_res.kind;
    assign o_field.field_id     = out_res.field_id;
    assign o_field.wtype        = out_res.wtype;
    assign o_field.value        = out_res.value;
    assign o_field.value_zigzag = out_res.value_zigzag;
    assign o_field.payload_byte = out_res.payload_byte;
    assign o_field.error_code   = out_res.error_code;
    assign o_field.last         = out_res.last;

endmodule

// File: dv/tb_top.sv
// self-checking testbench of the protobuf wire field decoder core
`timescale 1ns / 100ps

module tb_top;
    import pbwd_pkg::*;

    // timing and run shape
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned SETTLE_CYCLES = 6;     // two register stages plus margin
    localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no transaction at all
    localparam int unsigned LONG_HOLD     = 300;   // receiver hold-off that fills the block

    // largest length the decoder accepts
    localparam logic [63:0] LEN_LIMIT = 64'h0000_0000_7fff_ffff;

    // wire types the decoder rejects
    localparam logic [WT_W-1:0] WT_GROUP_START = 3'd3;
    localparam logic [WT_W-1:0] WT_GROUP_END   = 3'd4;
    localparam logic [WT_W-1:0] WT_RSVD6       = 3'd6;
    localparam logic [WT_W-1:0] WT_RSVD7       = 3'd7;

    // one input byte as offered, plus a written-out expectation where it is obvious
    typedef struct packed {
        logic [7:0]      data;
        logic            eom;
        logic            typed;   // use the columns below instead of the parser model
        logic            has;     // a result is expected
        t_kind           kind;
        logic [FN_W-1:0] fn;
        logic [WT_W-1:0] wt;
        t_err            err;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    pbwd_in_if  byte_if ();
    pbwd_out_if field_if ();
    pbwd_cfg_if cfg_if ();

    protobuf_wire_field_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_field (field_if),
        .i_cfg   (cfg_if)
    );

    // ------------------------------------------------------------------
    // parser model state, kept in step with the accepted byte stream
    // ------------------------------------------------------------------
    t_phase            wire_phase;
    logic [VAL_W-1:0]  wire_acc;
    logic [BCNT_W-1:0] wire_cnt;
    logic [FN_W-1:0]   held_fn;
    logic [WT_W-1:0]   held_wt;
    logic [REM_W-1:0]  payload_left;
    logic              pass_payload_now;

    t_result     expected_fields [$];   // results still owed by the block
    t_stim_row   offered_bytes [$];     // bytes put on the bus, oldest first
    logic [7:0]  msg_bytes [$];         // message under construction
    int unsigned parsed_items;          // accepted bytes
    int unsigned error_count;
    int unsigned hold_cycles;           // one-shot long stall request for the receiver
    int unsigned src_calm;
    int unsigned sink_calm;

    // directed bytes: reset state, extremes and the field number, wire type, no-data and varint errors
    t_stim_row directed_rows [24] = '{
        // field 1 varint with value zero right after reset
        '{8'h08, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'h00, 1'b0, 1'b1, 1'b1, KIND_FIELD, 29'd1, WT_VARINT, ERR_NONE},
        // field number zero, then the final byte is dropped
        '{8'h00, 1'b0, 1'b1, 1'b1, KIND_ERROR, 29'd0, WT_VARINT, ERR_FIELD_NUM},
        '{8'h55, 1'b1, 1'b1, 1'b1, KIND_END, 29'd0, WT_VARINT, ERR_NONE},
        // reserved wire type on the final byte carries last
        '{8'h0f, 1'b1, 1'b1, 1'b1, KIND_ERROR, 29'd1, WT_RSVD7, ERR_WIRE_TYPE},
        // tag alone ends the message
        '{8'h08, 1'b1, 1'b1, 1'b1, KIND_ERROR, 29'd1, WT_VARINT, ERR_NO_DATA},
        // empty payload completes at once
        '{8'h12, 1'b0, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        // two payload bytes, the last one ends the message
        '{8'h12, 1'b0, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'h02, 1'b0, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hab, 1'b0, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hcd, 1'b1, 1'b0, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        // varint whose tenth byte still continues
        '{8'h08, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'hff, 1'b0, 1'b1, 1'b0, KIND_FIELD, 29'd0, WT_VARINT, ERR_NONE},
        '{8'h81, 1'b0, 1'b1, 1'b1, KIND_ERROR, 29'd1, WT_VARINT, ERR_VARINT},
        '{8'h00, 1'b1, 1'b1, 1'b1, KIND_END, 29'd0, WT_VARINT, ERR_NONE}
    };

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------
    function automatic t_result make_result(input t_kind k, input logic [FN_W-1:0] fn,
                                            input logic [WT_W-1:0] wt,
                                            input logic [VAL_W-1:0] v,
                                            input logic [VAL_W-1:0] zz,
                                            input logic [7:0] pb, input t_err e,
                                            input logic lst);
        t_result r;
        r.kind         = k;
        r.field_id     = fn;
        r.wtype        = wt;
        r.value        = v;
        r.value_zigzag = zz;
        r.payload_byte = pb;
        r.error_code   = e;
        r.last         = lst;
        return r;
    endfunction

    // back to waiting for a tag
    function automatic void clear_parse();
        wire_phase   = PH_TAG;
        wire_acc     = '0;
        wire_cnt     = '0;
        held_fn      = '0;
        held_wt      = '0;
        payload_left = '0;
    endfunction

    // error result, then drop the rest of the message unless this byte ends it
    function automatic t_result fail_field(input t_err e, input logic eom);
        t_result r;
        r = make_result(KIND_ERROR, held_fn, held_wt, '0, '0, '0, e, eom);
        clear_parse();
        if (!eom) wire_phase = PH_DROP;
        return r;
    endfunction

    function automatic t_result field_done(input logic [VAL_W-1:0] v, input logic eom);
        logic [VAL_W-1:0] zz;
        zz = v[0] ? ~(v >> 1) : (v >> 1);
        return make_result(KIND_FIELD, held_fn, held_wt, v, zz, '0, ERR_NONE, eom);
    endfunction

    // one accepted byte in, at most one result out
    function automatic bit parse_byte(input logic [7:0] b, input logic eom,
                                      output t_result r);
        logic [VAL_W-1:0]  v;
        logic [31:0]       tag;
        logic [BCNT_W-1:0] need;
        logic [FN_W-1:0]   fn_keep;
        logic [WT_W-1:0]   wt_keep;
        r = '0;
        case (wire_phase)
            PH_TAG, PH_VARINT, PH_LEN: begin
                wire_acc |= {57'd0, b[6:0]} << (7 * wire_cnt);
                if (b[7]) begin
                    if (wire_cnt >= VARINT_LAST) begin
                        r = fail_field(ERR_VARINT, eom);
                        return 1'b1;
                    end
                    wire_cnt++;
                    if (eom) begin
                        r = fail_field(ERR_NO_DATA, eom);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                v        = wire_acc;
                wire_acc = '0;
                wire_cnt = '0;
                if (wire_phase == PH_TAG) begin
                    // wide tags keep their low 32 bits only
                    tag     = v[31:0];
                    held_fn = tag[31:3];
                    held_wt = tag[2:0];
                    if (held_fn == '0) begin
                        r = fail_field(ERR_FIELD_NUM, eom);
                        return 1'b1;
                    end
                    case (held_wt)
                        WT_VARINT:  wire_phase = PH_VARINT;
                        WT_FIXED64: wire_phase = PH_FIX64;
                        WT_LENGTH:  wire_phase = PH_LEN;
                        WT_FIXED32: wire_phase = PH_FIX32;
                        default: begin
                            r = fail_field(ERR_WIRE_TYPE, eom);
                            return 1'b1;
                        end
                    endcase
                    if (eom) begin
                        r = fail_field(ERR_NO_DATA, eom);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (wire_phase == PH_VARINT) begin
                    r = field_done(v, eom);
                    clear_parse();
                    return 1'b1;
                end
                // length prefix
                if (v > LEN_LIMIT) begin
                    r = fail_field(ERR_LENGTH, eom);
                    return 1'b1;
                end
                if (v == '0) begin
                    r = field_done(v, eom);
                    clear_parse();
                    return 1'b1;
                end
                if (eom) begin
                    r = fail_field(ERR_NO_DATA, eom);
                    return 1'b1;
                end
                payload_left = v[REM_W-1:0];
                wire_phase   = PH_PAYLOAD;
                r = field_done(v, 1'b0);
                return 1'b1;
            end
            PH_FIX64, PH_FIX32: begin
                need = (wire_phase == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
                wire_acc |= {56'd0, b} << (8 * wire_cnt[2:0]);
                wire_cnt++;
                if (wire_cnt >= need) begin
                    r = field_done(wire_acc, eom);
                    clear_parse();
                    return 1'b1;
                end
                if (eom) begin
                    r = fail_field(ERR_NO_DATA, eom);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_PAYLOAD: begin
                if (payload_left != '0) payload_left--;
                if (payload_left == '0) begin
                    fn_keep = held_fn;
                    wt_keep = held_wt;
                    clear_parse();
                    if (pass_payload_now) begin
                        r = make_result(KIND_PAYLOAD, fn_keep, wt_keep, '0, '0, b,
                                        ERR_NONE, eom);
                        return 1'b1;
                    end
                    if (eom) begin
                        r = make_result(KIND_END, '0, '0, '0, '0, '0, ERR_NONE, 1'b1);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (eom) begin
                    r = fail_field(ERR_NO_DATA, eom);
                    return 1'b1;
                end
                if (pass_payload_now) begin
                    r = make_result(KIND_PAYLOAD, held_fn, held_wt, '0, '0, b,
                                    ERR_NONE, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                // dropping after an error until the message ends
                if (eom) begin
                    clear_parse();
                    r = make_result(KIND_END, '0, '0, '0, '0, '0, ERR_NONE, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // message generation
    // ------------------------------------------------------------------
    // little-endian base-128, padded with redundant groups up to min_len
    function automatic void put_varint(input logic [63:0] v, input int unsigned min_len);
        int unsigned n;
        logic        more;
        n = 0;
        do begin
            n++;
            more = ((v >> 7) != '0 || n < min_len) && n < 10;
            msg_bytes.push_back({more, v[6:0]});
            v = v >> 7;
        end while (more);
    endfunction

    function automatic int unsigned pad_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    // tag, sometimes encoded wide with junk above bit 31
    function automatic void put_tag(input logic [FN_W-1:0] fn, input logic [WT_W-1:0] wt);
        logic [31:0] upper;
        upper = ($urandom_range(0, 9) == 0) ? $urandom() : 32'd0;
        put_varint({upper, fn, wt}, pad_len());
    endfunction

    function automatic logic [FN_W-1:0] pick_fn();
        case ($urandom_range(0, 3))
            0:       return 29'd1;
            1:       return 29'($urandom_range(1, 15));
            2:       return 29'($urandom_range(16, 4095));
            default: return 29'($urandom_range(1, 32'h1fff_ffff));
        endcase
    endfunction

    function automatic logic [63:0] pick_varint();
        case ($urandom_range(0, 5))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'($urandom_range(0, 127));
            4:       return {$urandom(), $urandom()} >> $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // one field, well formed or broken on purpose
    function automatic void add_field(input bit broken);
        logic [FN_W-1:0] fn;
        logic [WT_W-1:0] wt;
        logic [63:0]     huge_len;
        int unsigned     plen;
        fn = pick_fn();
        if (!broken) begin
            case ($urandom_range(0, 3))
                0:       wt = WT_VARINT;
                1:       wt = WT_FIXED64;
                2:       wt = WT_LENGTH;
                default: wt = WT_FIXED32;
            endcase
            put_tag(fn, wt);
            case (wt)
                WT_VARINT:  put_varint(pick_varint(), pad_len());
                WT_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom_range(0, 255)));
                WT_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom_range(0, 255)));
                default: begin
                    plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                       : $urandom_range(0, 6);
                    put_varint(64'(plen), pad_len());
                    repeat (plen) msg_bytes.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            case ($urandom_range(0, 3))
                // field number zero with any wire type
                0: put_tag('0, 3'($urandom_range(0, 7)));
                // rejected wire type
                1: begin
                    case ($urandom_range(0, 3))
                        0:       put_tag(fn, WT_GROUP_START);
                        1:       put_tag(fn, WT_GROUP_END);
                        2:       put_tag(fn, WT_RSVD6);
                        default: put_tag(fn, WT_RSVD7);
                    endcase
                end
                // varint that never stops
                2: begin
                    put_tag(fn, WT_VARINT);
                    repeat (10) msg_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
                end
                // length beyond the limit
                default: begin
                    put_tag(fn, WT_LENGTH);
                    huge_len = ($urandom_range(0, 3) == 0) ? 64'h8000_0000
                             : ({$urandom(), $urandom()} | 64'h8000_0000);
                    put_varint(huge_len, pad_len());
                end
            endcase
            // something after the error for the drop state to eat
            repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // mostly well-formed messages, some truncated, some broken, some noise
    function automatic void build_message();
        int unsigned cut;
        msg_bytes.delete();
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 4)) add_field($urandom_range(0, 11) == 0);
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
            end
        end
    endfunction

    function automatic t_stim_row plain_row(input logic [7:0] data, input logic eom);
        t_stim_row row;
        row      = '0;
        row.kind = KIND_FIELD;
        row.err  = ERR_NONE;
        row.data = data;
        row.eom  = eom;
        return row;
    endfunction

    // idle cycles before the next transaction, with calm stretches of none
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    // offer one byte and return at the edge it is taken
    task automatic send_item(input t_stim_row row);
        int unsigned gap;
        gap = draw_gap(src_calm);
        if (gap != 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_bytes.push_back(row);
        byte_if.valid          <= 1'b1;
        byte_if.data_byte      <= row.data;
        byte_if.end_of_message <= row.eom;
        do @(posedge i_clk); while (byte_if.ready !== 1'b1);
    endtask

    task automatic write_pass_payload(input logic val);
        cfg_if.valid        <= 1'b1;
        cfg_if.pass_payload <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid     <= 1'b0;
        pass_payload_now = val;
    endtask

    task automatic run_random(input int unsigned target);
        int unsigned start;
        start = parsed_items;
        while (parsed_items - start < target) begin
            build_message();
            foreach (msg_bytes[k]) send_item(plain_row(msg_bytes[k], k == msg_bytes.size() - 1));
        end
    endtask

    // stop offering, let every owed result arrive, then let the pipe empty
    task automatic settle();
        byte_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // input monitor: every accepted byte goes through the parser model
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_monitor
        t_stim_row row;
        t_result   res;
        bit        got;
        if (i_rst_n && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
            row = offered_bytes.pop_front();
            parsed_items++;
            got = parse_byte(row.data, row.eom, res);
            // written-out rows override the model, whose state still advances
            if (row.typed) begin
                got = row.has;
                res = make_result(row.kind, row.fn, row.wt, '0, '0, '0, row.err, row.eom);
            end
            if (got) expected_fields.push_back(res);
        end
    end

    // ------------------------------------------------------------------
    // output monitor: compare each result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : field_checker
        t_result want;
        if (i_rst_n && field_if.valid === 1'b1 && field_if.ready === 1'b1) begin
            if (expected_fields.size() == 0) begin
                report_mismatch("unexpected result, kind", field_if.kind, '0);
            end else begin
                want = expected_fields.pop_front();
                if (field_if.kind !== want.kind)
                    report_mismatch("kind", field_if.kind, want.kind);
                if (field_if.field_id !== want.field_id)
                    report_mismatch("field_id", field_if.field_id, want.field_id);
                if (field_if.wtype !== want.wtype)
                    report_mismatch("wtype", field_if.wtype, want.wtype);
                if (field_if.value !== want.value)
                    report_mismatch("value", field_if.value, want.value);
                if (field_if.value_zigzag !== want.value_zigzag)
                    report_mismatch("value_zigzag", field_if.value_zigzag, want.value_zigzag);
                if (field_if.payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", field_if.payload_byte, want.payload_byte);
                if (field_if.error_code !== want.error_code)
                    report_mismatch("error_code", field_if.error_code, want.error_code);
                if (field_if.last !== want.last)
                    report_mismatch("last", field_if.last, want.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, calm stretches and one long hold-off
    // ------------------------------------------------------------------
    initial begin : field_sink
        int unsigned stall;
        forever begin
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = draw_gap(sink_calm);
            end
            if (stall != 0) begin
                field_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            field_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && field_if.valid === 1'b1));
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
                (field_if.valid === 1'b1 && field_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        byte_if.valid          <= 1'b0;
        byte_if.data_byte      <= 8'd0;
        byte_if.end_of_message <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.pass_payload    <= 1'b1;
        i_rst_n                <= 1'b0;
        parsed_items     = 0;
        error_count      = 0;
        hold_cycles      = 0;
        src_calm         = 0;
        sink_calm        = 0;
        pass_payload_now = 1'b1;
        clear_parse();

        // single synchronous reset at the start
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed bytes with the reset setting, payload passed on
        foreach (directed_rows[k]) send_item(directed_rows[k]);
        settle();

        // payload skipped: a final payload byte that ends the message turns into a bare message end
        write_pass_payload(1'b0);
        run_random(450);
        settle();

        // payload passed on, receiver holds off early so the input stalls
        write_pass_payload(1'b1);
        hold_cycles = LONG_HOLD;
        run_random(500);
        settle();

        write_pass_payload(1'b0);
        run_random(400);
        settle();

        write_pass_payload(1'b1);
        run_random(500);
        settle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
